>>> design/sec_pkg.sv
// shared types, constants and saturation helper for the sphere collision core
package sec_pkg;

  typedef logic signed [19:0] comp_t;
  typedef logic signed [27:0] wide_t;

  typedef struct packed {
    logic [20:0] mag;
    logic        neg;
    logic        zero;
  } dir_t;

  typedef struct packed {
    logic [59:0] p1;
    logic [59:0] v1;
    logic [31:0] c1;
    logic [59:0] p2;
    logic [59:0] v2;
    logic [31:0] c2;
  } pair_t;

  localparam int    PAIR_W      = $bits(pair_t);
  localparam comp_t COMP_MAX    = 20'sh7FFFF;
  localparam comp_t COMP_MIN    = 20'sh80000;
  localparam logic [49:0] SCALE_LIMIT = 50'd1 << 46;
  localparam logic [38:0] PUSH_LIMIT  = 39'd1 << 20;
  localparam logic [43:0] SPEED_LIMIT = 44'd65536;

  function automatic comp_t sat_comp(input wide_t v);
    comp_t r;
    if (v > wide_t'(COMP_MAX)) begin
      r = COMP_MAX;
    end else if (v < wide_t'(COMP_MIN)) begin
      r = COMP_MIN;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

>>> design/sphere_elastic_collision_core.sv
// top level of the pipelined elastic sphere collision core
// one word per cycle sustained
// depth is set by the bit-per-stage square root, direction and velocity dividers in series
// busy stays low: the receiver cannot stall, so every cycle may start a new pair
// synchronous reset clears the valid pipeline only; data registers are not reset
module sphere_elastic_collision_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [59:0] first_position,
  input  logic [59:0] first_velocity,
  input  logic [15:0] first_mass,
  input  logic [15:0] first_radius,
  input  logic [31:0] first_colour,
  input  logic [59:0] second_position,
  input  logic [59:0] second_velocity,
  input  logic [15:0] second_mass,
  input  logic [15:0] second_radius,
  input  logic [31:0] second_colour,
  output logic        hit,
  output logic [59:0] first_position_out,
  output logic [59:0] first_velocity_out,
  output logic [31:0] first_colour_out,
  output logic [59:0] second_position_out,
  output logic [59:0] second_velocity_out,
  output logic [31:0] second_colour_out
);
  import sec_pkg::*;

  localparam int SQ_LAT = 25;
  localparam int U_LAT  = 17;
  localparam int S_LAT  = 50;
  localparam int V_LAT  = 40;
  localparam int T_D    = 2;
  localparam int T_SQI  = 3;
  localparam int T_LEN  = T_SQI + SQ_LAT;
  localparam int T_UQ   = T_LEN + U_LAT;
  localparam int T_U    = T_UQ + 1;
  localparam int T_SN   = T_SQI + 1;
  localparam int T_SQ   = T_SN + S_LAT;
  localparam int T_SC   = ((T_SQ > T_U) ? T_SQ : T_U) + 1;
  localparam int T_PP   = T_SC + 1;
  localparam int T_PM   = T_PP + 1;
  localparam int T_PN   = T_PM + 1;
  localparam int T_AB   = T_U + 1;
  localparam int T_AS   = T_AB + 1;
  localparam int T_DM   = T_AS + 1;
  localparam int T_PV   = T_DM + 1;
  localparam int T_NV   = T_PV + 1;
  localparam int T_DV   = T_NV + V_LAT;
  localparam int T_DP   = T_DV + 1;
  localparam int T_DL   = T_DP + 1;
  localparam int T_VN   = T_DL + 1;
  localparam int T_SQS  = T_VN + 1;
  localparam int T_CMP  = T_SQS + 1;
  localparam int T_OUT  = T_CMP + 1;

  // valid pipeline
  logic [T_OUT:1] vs;
  assign busy = 1'b0;
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else begin
      vs <= {vs[T_OUT-1:1], start & ~busy};
    end
  end
  assign done = vs[T_OUT];

  // stage 1: capture and differences
  pair_t              raw1;
  logic signed [20:0] d1 [3];
  logic [15:0]        mm1_1, mm2_1;
  logic [16:0]        rsum1;
  always_ff @(posedge clk) begin
    raw1.p1 <= first_position;
    raw1.v1 <= first_velocity;
    raw1.c1 <= first_colour;
    raw1.p2 <= second_position;
    raw1.v2 <= second_velocity;
    raw1.c2 <= second_colour;
    for (int k = 0; k < 3; k++) begin
      d1[k] <= {second_position[20*k+19], second_position[20*k +: 20]}
             - {first_position[20*k+19], first_position[20*k +: 20]};
    end
    mm1_1 <= (first_mass == '0) ? 16'd1 : first_mass;
    mm2_1 <= (second_mass == '0) ? 16'd1 : second_mass;
    rsum1 <= {1'b0, first_radius} + {1'b0, second_radius};
  end

  // stage 2: squares and direction magnitudes
  logic signed [41:0] dsq_c [3];
  logic [33:0]        rsq_c;
  logic [40:0]        dsq2 [3];
  logic [33:0]        rsq2;
  logic [15:0]        mm1_2, mm2_2;
  dir_t [2:0]         dir2;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsq_c[k] = d1[k] * d1[k];
    end
    rsq_c = rsum1 * rsum1;
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dsq2[k]      <= dsq_c[k][40:0];
      dir2[k].mag  <= d1[k][20] ? 21'(-d1[k]) : 21'(d1[k]);
      dir2[k].neg  <= d1[k][20];
      dir2[k].zero <= (d1[k] == '0);
    end
    rsq2  <= rsq_c;
    mm1_2 <= mm1_1;
    mm2_2 <= mm2_1;
  end

  // stage 3: distance, depth, contact
  logic [42:0] dist_c;
  logic [33:0] dist3, depth3;
  logic        hit3;
  logic [15:0] mm1_3, mm2_3;
  assign dist_c = 43'(dsq2[0]) + 43'(dsq2[1]) + 43'(dsq2[2]);
  always_ff @(posedge clk) begin
    dist3  <= dist_c[33:0];
    depth3 <= rsq2 - dist_c[33:0];
    hit3   <= {9'b0, rsq2} > dist_c;
    mm1_3  <= mm1_2;
    mm2_3  <= mm2_2;
  end

  // centre distance and unit direction
  logic [24:0] len;
  sec_isqrt #(.XW(50)) u_sqrt (
    .clk (clk),
    .x   ({dist3, 16'b0}),
    .root(len)
  );

  dir_t [2:0] dir_l;
  sec_delay #(.W($bits(dir_t) * 3), .D(T_LEN - T_D)) u_dir_dly (
    .clk(clk), .d(dir2), .q(dir_l)
  );

  logic [16:0] uq [3];
  logic [5:0]  uflag_l, uflag_q;
  genvar gk;
  generate
    for (gk = 0; gk < 3; gk++) begin : g_udiv
      sec_div #(.NW(45), .DW(25), .QW(17)) u_div (
        .clk(clk), .num({dir_l[gk].mag, 24'b0}), .den(len), .quo(uq[gk])
      );
      assign uflag_l[2*gk]   = dir_l[gk].neg;
      assign uflag_l[2*gk+1] = dir_l[gk].zero;
    end
  endgenerate
  sec_delay #(.W(6), .D(U_LAT)) u_uflag_dly (.clk(clk), .d(uflag_l), .q(uflag_q));

  logic [16:0]        umag [3];
  logic [2:0]         uneg;
  logic signed [17:0] usg [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      umag[k] <= uflag_q[2*k+1] ? 17'd0 : uq[k];
      uneg[k] <= uflag_q[2*k];
    end
  end
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      usg[k] = uneg[k] ? -$signed({1'b0, umag[k]}) : $signed({1'b0, umag[k]});
    end
  end

  // input word alignment
  pair_t raw_u, raw_p, raw_c;
  sec_delay #(.W(PAIR_W), .D(T_U - 1)) u_raw_a (.clk(clk), .d(raw1), .q(raw_u));
  sec_delay #(.W(PAIR_W), .D(T_PM - T_U)) u_raw_b (.clk(clk), .d(raw_u), .q(raw_p));
  sec_delay #(.W(PAIR_W), .D(T_CMP - T_PM)) u_raw_c (.clk(clk), .d(raw_p), .q(raw_c));

  // push scale
  logic [49:0] n1_c, n2_c, n1, n2;
  logic [15:0] mm1_4, mm2_4;
  assign n1_c = depth3 * mm2_3;
  assign n2_c = depth3 * mm1_3;
  always_ff @(posedge clk) begin
    n1    <= n1_c;
    n2    <= n2_c;
    mm1_4 <= mm1_3;
    mm2_4 <= mm2_3;
  end

  logic [49:0] sq1, sq2, sq1_d, sq2_d;
  sec_div #(.NW(50), .DW(16), .QW(50)) u_s1 (.clk(clk), .num(n1), .den(mm1_4), .quo(sq1));
  sec_div #(.NW(50), .DW(16), .QW(50)) u_s2 (.clk(clk), .num(n2), .den(mm2_4), .quo(sq2));
  sec_delay #(.W(100), .D(T_SC - 1 - T_SQ)) u_s_dly (
    .clk(clk), .d({sq2, sq1}), .q({sq2_d, sq1_d})
  );

  logic [53:0] uvec_u, uvec_p, uvec_v;
  assign uvec_u = {uneg, umag[2], umag[1], umag[0]};
  sec_delay #(.W(54), .D(T_SC - 1 - T_U)) u_up_dly (.clk(clk), .d(uvec_u), .q(uvec_p));
  sec_delay #(.W(54), .D(T_DV - T_U)) u_uv_dly (.clk(clk), .d(uvec_u), .q(uvec_v));

  logic [46:0] sc1, sc2;
  logic [16:0] upm [3];
  logic [2:0]  upn_sc, upn_pp, upn_pm;
  always_ff @(posedge clk) begin
    sc1 <= (sq1_d > SCALE_LIMIT) ? SCALE_LIMIT[46:0] : sq1_d[46:0];
    sc2 <= (sq2_d > SCALE_LIMIT) ? SCALE_LIMIT[46:0] : sq2_d[46:0];
    for (int k = 0; k < 3; k++) begin
      upm[k] <= uvec_p[17*k +: 17];
    end
    upn_sc <= uvec_p[53:51];
  end

  logic [40:0] pl1 [3], pl2 [3];
  logic [39:0] ph1 [3], ph2 [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl1[k] <= upm[k] * sc1[23:0];
      ph1[k] <= upm[k] * sc1[46:24];
      pl2[k] <= upm[k] * sc2[23:0];
      ph2[k] <= upm[k] * sc2[46:24];
    end
    upn_pp <= upn_sc;
  end

  logic [63:0] pf1 [3], pf2 [3];
  logic [20:0] push1 [3], push2 [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pf1[k] = (64'(ph1[k]) << 24) + 64'(pl1[k]);
      pf2[k] = (64'(ph2[k]) << 24) + 64'(pl2[k]);
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      push1[k] <= (pf1[k][63:25] > PUSH_LIMIT) ? PUSH_LIMIT[20:0] : pf1[k][45:25];
      push2[k] <= (pf2[k][63:25] > PUSH_LIMIT) ? PUSH_LIMIT[20:0] : pf2[k][45:25];
    end
    upn_pm <= upn_pp;
  end

  comp_t pn1 [3], pn2 [3];
  wide_t pp1 [3], pp2 [3], pd1 [3], pd2 [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pp1[k] = wide_t'($signed(raw_p.p1[20*k +: 20]));
      pp2[k] = wide_t'($signed(raw_p.p2[20*k +: 20]));
      pd1[k] = wide_t'({1'b0, push1[k]});
      pd2[k] = wide_t'({1'b0, push2[k]});
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pn1[k] <= sat_comp(upn_pm[k] ? pp1[k] + pd1[k] : pp1[k] - pd1[k]);
      pn2[k] <= sat_comp(upn_pm[k] ? pp2[k] - pd2[k] : pp2[k] + pd2[k]);
    end
  end

  logic [119:0] pnew_c;
  sec_delay #(.W(120), .D(T_CMP - T_PN)) u_pn_dly (
    .clk(clk),
    .d  ({pn2[2], pn2[1], pn2[0], pn1[2], pn1[1], pn1[0]}),
    .q  (pnew_c)
  );

  // projected speeds
  logic signed [37:0] pa [3], pb [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pa[k] <= $signed(raw_u.v1[20*k +: 20]) * usg[k];
      pb[k] <= $signed(raw_u.v2[20*k +: 20]) * usg[k];
    end
  end

  logic signed [39:0] sa, sb;
  always_ff @(posedge clk) begin
    sa <= 40'(pa[0]) + 40'(pa[1]) + 40'(pa[2]);
    sb <= 40'(pb[0]) + 40'(pb[1]) + 40'(pb[2]);
  end

  logic signed [40:0] vdiff;
  logic [39:0]        dmagv;
  logic               dnegv;
  assign vdiff = 41'(sb) - 41'(sa);
  always_ff @(posedge clk) begin
    dmagv <= vdiff[40] ? 40'(-vdiff) : vdiff[39:0];
    dnegv <= vdiff[40];
  end

  logic [31:0] mmv;
  sec_delay #(.W(32), .D(T_DM - T_SQI)) u_mm_dly (
    .clk(clk), .d({mm2_3, mm1_3}), .q(mmv)
  );

  logic [35:0] plA, phA, plB, phB;
  logic [16:0] msum_pv, msum_nv;
  always_ff @(posedge clk) begin
    plA     <= mmv[31:16] * dmagv[19:0];
    phA     <= mmv[31:16] * dmagv[39:20];
    plB     <= mmv[15:0] * dmagv[19:0];
    phB     <= mmv[15:0] * dmagv[39:20];
    msum_pv <= {1'b0, mmv[15:0]} + {1'b0, mmv[31:16]};
  end

  logic [55:0] numA_c, numB_c;
  logic [56:0] numA, numB;
  assign numA_c = (56'(phA) << 20) + 56'(plA);
  assign numB_c = (56'(phB) << 20) + 56'(plB);
  always_ff @(posedge clk) begin
    numA    <= {numA_c, 1'b0};
    numB    <= {numB_c, 1'b0};
    msum_nv <= msum_pv;
  end

  logic [39:0] qa, qb;
  sec_div #(.NW(57), .DW(17), .QW(40)) u_dva (.clk(clk), .num(numA), .den(msum_nv), .quo(qa));
  sec_div #(.NW(57), .DW(17), .QW(40)) u_dvb (.clk(clk), .num(numB), .den(msum_nv), .quo(qb));

  logic dneg_v;
  sec_delay #(.W(1), .D(T_DV - T_DM)) u_dneg_dly (.clk(clk), .d(dnegv), .q(dneg_v));

  // velocity change along the direction
  logic [36:0] la [3], ha [3], lb [3], hb [3];
  logic [2:0]  na, nb;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      la[k] <= qa[19:0] * uvec_v[17*k +: 17];
      ha[k] <= qa[39:20] * uvec_v[17*k +: 17];
      lb[k] <= qb[19:0] * uvec_v[17*k +: 17];
      hb[k] <= qb[39:20] * uvec_v[17*k +: 17];
      na[k] <= dneg_v ^ uvec_v[51+k];
      nb[k] <= ~dneg_v ^ uvec_v[51+k];
    end
  end

  logic [57:0]        fa [3], fb [3];
  logic signed [26:0] dla [3], dlb [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fa[k] = (58'(ha[k]) << 20) + 58'(la[k]);
      fb[k] = (58'(hb[k]) << 20) + 58'(lb[k]);
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dla[k] <= na[k] ? -$signed({1'b0, fa[k][57:32]}) : $signed({1'b0, fa[k][57:32]});
      dlb[k] <= nb[k] ? -$signed({1'b0, fb[k][57:32]}) : $signed({1'b0, fb[k][57:32]});
    end
  end

  logic [119:0] vold;
  sec_delay #(.W(120), .D(T_DL - T_U)) u_v_dly (
    .clk(clk), .d({raw_u.v2, raw_u.v1}), .q(vold)
  );

  comp_t vn1 [3], vn2 [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      vn1[k] <= sat_comp(wide_t'($signed(vold[20*k +: 20])) + wide_t'(dla[k]));
      vn2[k] <= sat_comp(wide_t'($signed(vold[60+20*k +: 20])) + wide_t'(dlb[k]));
    end
  end

  // colour transfer test
  logic signed [20:0] vs_c [3];
  logic signed [41:0] ss_c [3];
  logic signed [39:0] l1_c [3], l2_c [3];
  logic [40:0]        ssq [3];
  logic [39:0]        l1q [3], l2q [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vs_c[k] = 21'(vn1[k]) + 21'(vn2[k]);
      ss_c[k] = vs_c[k] * vs_c[k];
      l1_c[k] = vn1[k] * vn1[k];
      l2_c[k] = vn2[k] * vn2[k];
    end
  end
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ssq[k] <= ss_c[k][40:0];
      l1q[k] <= l1_c[k];
      l2q[k] <= l2_c[k];
    end
  end

  logic [43:0] sum2_c;
  logic [41:0] l1s_c, l2s_c;
  logic        big, less;
  assign sum2_c = 44'(ssq[0]) + 44'(ssq[1]) + 44'(ssq[2]);
  assign l1s_c  = 42'(l1q[0]) + 42'(l1q[1]) + 42'(l1q[2]);
  assign l2s_c  = 42'(l2q[0]) + 42'(l2q[1]) + 42'(l2q[2]);
  always_ff @(posedge clk) begin
    big  <= sum2_c > SPEED_LIMIT;
    less <= l1s_c < l2s_c;
  end

  logic [119:0] vnew_c;
  sec_delay #(.W(120), .D(T_CMP - T_VN)) u_vn_dly (
    .clk(clk),
    .d  ({vn2[2], vn2[1], vn2[0], vn1[2], vn1[1], vn1[0]}),
    .q  (vnew_c)
  );

  logic hit_c;
  sec_delay #(.W(1), .D(T_CMP - T_SQI)) u_hit_dly (.clk(clk), .d(hit3), .q(hit_c));

  // result word
  always_ff @(posedge clk) begin
    hit <= hit_c;
    if (hit_c) begin
      first_position_out  <= pnew_c[59:0];
      second_position_out <= pnew_c[119:60];
      first_velocity_out  <= vnew_c[59:0];
      second_velocity_out <= vnew_c[119:60];
      first_colour_out    <= (big && !less) ? raw_c.c2 : raw_c.c1;
      second_colour_out   <= (big && less) ? raw_c.c1 : raw_c.c2;
    end else begin
      first_position_out  <= raw_c.p1;
      second_position_out <= raw_c.p2;
      first_velocity_out  <= raw_c.v1;
      second_velocity_out <= raw_c.v2;
      first_colour_out    <= raw_c.c1;
      second_colour_out   <= raw_c.c2;
    end
  end

endmodule

>>> design/sec_delay.sv
// fixed-length shift register for aligning side data
module sec_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  generate
    if (D == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] sr [0:D-1];
      always_ff @(posedge clk) begin
        sr[0] <= d;
        for (int i = 1; i < D; i++) begin
          sr[i] <= sr[i-1];
        end
      end
      assign q = sr[D-1];
    end
  endgenerate
endmodule

>>> design/sec_isqrt.sv
// pipelined integer square root, one result bit per stage
module sec_isqrt #(
  parameter int XW = 50
) (
  input  logic              clk,
  input  logic [XW-1:0]     x,
  output logic [XW/2-1:0]   root
);
  localparam int RW = XW / 2;

  logic [XW-1:0] xr [1:RW-1];
  logic [XW-1:0] rr [1:RW];

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_stage
      localparam logic [XW:0] BIT = (XW+1)'(1) << (XW - 2 - 2*k);
      logic [XW-1:0] xin;
      logic [XW-1:0] rin;
      logic [XW:0]   sum;
      logic [XW:0]   rup;
      logic          ge;
      if (k == 0) begin : g_first
        assign xin = x;
        assign rin = '0;
      end else begin : g_next
        assign xin = xr[k];
        assign rin = rr[k];
      end
      assign sum = {1'b0, rin} + BIT;
      assign ge  = {1'b0, xin} >= sum;
      assign rup = {1'b0, rin >> 1} + BIT;
      always_ff @(posedge clk) begin
        rr[k+1] <= ge ? rup[XW-1:0] : (rin >> 1);
      end
      if (k < RW - 1) begin : g_rem
        always_ff @(posedge clk) begin
          xr[k+1] <= ge ? (xin - sum[XW-1:0]) : xin;
        end
      end
    end
  endgenerate

  assign root = rr[RW][RW-1:0];
endmodule

>>> design/sec_div.sv
// pipelined restoring divider, one quotient bit per stage
module sec_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  localparam int CW = NW + DW + QW;

  logic [NW-1:0] rem [1:QW-1];
  logic [DW-1:0] dr  [1:QW-1];
  logic [QW-1:0] qr  [1:QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      localparam int SH = QW - 1 - k;
      logic [NW-1:0] rin;
      logic [DW-1:0] din;
      logic [QW-1:0] qin;
      logic [CW-1:0] trial;
      logic [CW-1:0] diff;
      logic          ge;
      if (k == 0) begin : g_first
        assign rin = num;
        assign din = den;
        assign qin = '0;
      end else begin : g_next
        assign rin = rem[k];
        assign din = dr[k];
        assign qin = qr[k];
      end
      assign trial = CW'(din) << SH;
      assign ge    = CW'(rin) >= trial;
      assign diff  = CW'(rin) - trial;
      always_ff @(posedge clk) begin
        qr[k+1] <= (qin << 1) | QW'(ge);
      end
      if (k < QW - 1) begin : g_rem
        always_ff @(posedge clk) begin
          rem[k+1] <= ge ? diff[NW-1:0] : rin;
          dr[k+1]  <= din;
        end
      end
    end
  endgenerate

  assign quo = qr[QW];
endmodule

>>> tb/sphere_elastic_collision_core_checker.sv
// checker for the sphere collision core: predicts each pair's response and compares results
`timescale 1ns / 100ps
module sphere_elastic_collision_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        done,
  input  logic [59:0] first_position,
  input  logic [59:0] first_velocity,
  input  logic [15:0] first_mass,
  input  logic [15:0] first_radius,
  input  logic [31:0] first_colour,
  input  logic [59:0] second_position,
  input  logic [59:0] second_velocity,
  input  logic [15:0] second_mass,
  input  logic [15:0] second_radius,
  input  logic [31:0] second_colour,
  input  logic        hit,
  input  logic [59:0] first_position_out,
  input  logic [59:0] first_velocity_out,
  input  logic [31:0] first_colour_out,
  input  logic [59:0] second_position_out,
  input  logic [59:0] second_velocity_out,
  input  logic [31:0] second_colour_out,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        hit;
    logic [59:0] p1;
    logic [59:0] v1;
    logic [31:0] c1;
    logic [59:0] p2;
    logic [59:0] v2;
    logic [31:0] c2;
  } response_t;

  response_t expected_responses[$];

  function automatic longint unpack_comp(input logic [59:0] w, input int k);
    logic signed [19:0] f;
    f = w[20*k +: 20];
    return longint'(f);
  endfunction

  function automatic longint clamp_comp(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint push_of(input longint u, input longint unsigned s);
    longint unsigned m, pm;
    m = (u < 0) ? longint'(-u) : longint'(u);
    pm = (m * s) >> 25;
    if (pm > 64'd1048576) pm = 64'd1048576;
    return (u < 0) ? -longint'(pm) : longint'(pm);
  endfunction

  function automatic response_t collide(
      input logic [59:0] ip1, iv1, input logic [15:0] im1, ir1, input logic [31:0] ic1,
      input logic [59:0] ip2, iv2, input logic [15:0] im2, ir2, input logic [31:0] ic2);
    response_t r;
    longint p1[3], v1[3], p2[3], v2[3], d[3], u[3];
    longint unsigned m1, m2, dist2, rsq, depth, len, s1, s2, sum2, l1, l2;
    longint a, b, dva, dvb, msum, t;
    logic [31:0] c1, c2;
    dist2 = 0; a = 0; b = 0; sum2 = 0; l1 = 0; l2 = 0;
    c1 = ic1; c2 = ic2;
    for (int k = 0; k < 3; k++) begin
      p1[k] = unpack_comp(ip1, k); v1[k] = unpack_comp(iv1, k);
      p2[k] = unpack_comp(ip2, k); v2[k] = unpack_comp(iv2, k);
      d[k] = p2[k] - p1[k];
      dist2 += longint'(d[k] * d[k]);
    end
    m1 = (im1 == 0) ? 1 : im1;
    m2 = (im2 == 0) ? 1 : im2;
    rsq = (64'(ir1) + 64'(ir2)) * (64'(ir1) + 64'(ir2));
    r = '{hit: 1'b0, p1: ip1, v1: iv1, c1: ic1, p2: ip2, v2: iv2, c2: ic2};
    if (rsq <= dist2) return r;
    depth = rsq - dist2;
    len = int_sqrt(dist2 << 16);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) u[k] = 0;
      else begin
        u[k] = (d[k] * 64'sd16777216) / longint'(len);
        if (u[k] > 65536) u[k] = 65536;
        if (u[k] < -65536) u[k] = -65536;
      end
    end
    s1 = depth * m2 / m1;
    s2 = depth * m1 / m2;
    if (s1 > (64'd1 << 46)) s1 = 64'd1 << 46;
    if (s2 > (64'd1 << 46)) s2 = 64'd1 << 46;
    for (int k = 0; k < 3; k++) begin
      p1[k] = clamp_comp(p1[k] - push_of(u[k], s1));
      p2[k] = clamp_comp(p2[k] + push_of(u[k], s2));
      a += v1[k] * u[k];
      b += v2[k] * u[k];
    end
    msum = longint'(m1 + m2);
    dva = (2 * longint'(m2) * (b - a)) / msum;
    dvb = (2 * longint'(m1) * (a - b)) / msum;
    for (int k = 0; k < 3; k++) begin
      v1[k] = clamp_comp(v1[k] + (dva * u[k]) / 64'sd4294967296);
      v2[k] = clamp_comp(v2[k] + (dvb * u[k]) / 64'sd4294967296);
      t = v1[k] + v2[k];
      sum2 += longint'(t * t);
      l1 += longint'(v1[k] * v1[k]);
      l2 += longint'(v2[k] * v2[k]);
    end
    if (sum2 > 65536) begin
      if (l1 < l2) c2 = c1;
      else c1 = c2;
    end
    r.hit = 1'b1;
    r.c1 = c1;
    r.c2 = c2;
    for (int k = 0; k < 3; k++) begin
      r.p1[20*k +: 20] = p1[k][19:0];
      r.v1[20*k +: 20] = v1[k][19:0];
      r.p2[20*k +: 20] = p2[k][19:0];
      r.v2[20*k +: 20] = v2[k][19:0];
    end
    return r;
  endfunction

  assign pending = expected_responses.size();

  always @(posedge clk) begin
    response_t want;
    response_t got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        expected_responses.insert(expected_responses.size(), collide(first_position,
          first_velocity, first_mass, first_radius, first_colour, second_position,
          second_velocity, second_mass, second_radius, second_colour));
      if (done) begin
        got = '{hit, first_position_out, first_velocity_out, first_colour_out,
                second_position_out, second_velocity_out, second_colour_out};
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_responses.pop_front();
          if (want.hit !== got.hit) $display("%0t: hit exp %h got %h", $time, want.hit, got.hit);
          if (want.p1 !== got.p1) $display("%0t: p1 exp %h got %h", $time, want.p1, got.p1);
          if (want.v1 !== got.v1) $display("%0t: v1 exp %h got %h", $time, want.v1, got.v1);
          if (want.c1 !== got.c1) $display("%0t: c1 exp %h got %h", $time, want.c1, got.c1);
          if (want.p2 !== got.p2) $display("%0t: p2 exp %h got %h", $time, want.p2, got.p2);
          if (want.v2 !== got.v2) $display("%0t: v2 exp %h got %h", $time, want.v2, got.v2);
          if (want.c2 !== got.c2) $display("%0t: c2 exp %h got %h", $time, want.c2, got.c2);
          if (want !== got) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

>>> tb/sphere_elastic_collision_core_test.sv
// stimulus and verdict for the sphere collision core
`timescale 1ns / 100ps
module sphere_elastic_collision_core_test;

  localparam int LATENCY = 97;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy, done, hit;
  logic [59:0] first_position = '0, first_velocity = '0;
  logic [59:0] second_position = '0, second_velocity = '0;
  logic [15:0] first_mass = 16'd1, first_radius = '0, second_mass = 16'd1, second_radius = '0;
  logic [31:0] first_colour = '0, second_colour = '0;
  logic [59:0] first_position_out, first_velocity_out, second_position_out, second_velocity_out;
  logic [31:0] first_colour_out, second_colour_out;
  int          fail_count, pending, cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sphere_elastic_collision_core dut (.*);
  sphere_elastic_collision_core_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sphere_elastic_collision_core_test: FAIL");
      $finish;
    end
  end

  function automatic logic [19:0] rand_comp(input int spread);
    case ($urandom_range(0, 3))
      0: return 20'($urandom);
      1: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      default: return 20'($signed($urandom_range(0, 2 * spread)) - spread);
    endcase
  endfunction

  function automatic logic [59:0] rand_vec(input int spread);
    return {rand_comp(spread), rand_comp(spread), rand_comp(spread)};
  endfunction

  task automatic send_pair(input logic [59:0] p1, v1, input logic [15:0] m1, r1,
                           input logic [31:0] c1, input logic [59:0] p2, v2,
                           input logic [15:0] m2, r2, input logic [31:0] c2, input bit calm);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    first_position <= p1; first_velocity <= v1; first_mass <= m1;
    first_radius <= r1; first_colour <= c1;
    second_position <= p2; second_velocity <= v2; second_mass <= m2;
    second_radius <= r2; second_colour <= c2;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random(input bit calm);
    logic [59:0] p1, d;
    int spread;
    spread = $urandom_range(0, 1) ? 2000 : 60000;
    p1 = rand_vec(200000);
    d = {20'($signed($urandom_range(0, 2 * spread)) - spread),
         20'($signed($urandom_range(0, 2 * spread)) - spread),
         20'($signed($urandom_range(0, 2 * spread)) - spread)};
    if ($urandom_range(0, 9) == 0) d = '0;
    send_pair(p1, rand_vec(3000), 16'($urandom), 16'($urandom), $urandom,
      {p1[59:40] + d[59:40], p1[39:20] + d[39:20], p1[19:0] + d[19:0]},
      rand_vec(3000), 16'($urandom), 16'($urandom), $urandom, calm);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // no contact, coincident centres, extremes, zero mass, large push
    send_pair('0, '0, 16'd256, 16'd0, 32'h11111111, {3{20'd5000}}, '0, 16'd256, 16'd0,
              32'h22222222, 1'b1);
    send_pair('0, {3{20'd300}}, 16'd256, 16'd256, 32'hAAAAAAAA, '0, {3{20'hFFF00}}, 16'd512,
              16'd256, 32'h55555555, 1'b1);
    send_pair({3{20'h80000}}, {3{20'h7FFFF}}, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
              {3{20'h7FFFF}}, {3{20'h80000}}, 16'd1, 16'hFFFF, 32'h0, 1'b1);
    send_pair('0, {20'd0, 20'd0, 20'd1000}, 16'd0, 16'd2560, 32'h01020304,
              {20'd0, 20'd0, 20'd256}, {20'd0, 20'd0, 20'hFFC00}, 16'd0, 16'd2560,
              32'h0A0B0C0D, 1'b1);
    send_pair({3{20'h7FFFF}}, {3{20'h80000}}, 16'd1, 16'hFFFF, 32'h0F0F0F0F,
              {3{20'h7FFFE}}, {3{20'h7FFFF}}, 16'hFFFF, 16'hFFFF, 32'hF0F0F0F0, 1'b1);
    send_pair({20'd0, 20'd100, 20'hFFF00}, {20'd10, 20'd0, 20'd0}, 16'd256, 16'd128,
              32'h12345678, {20'd0, 20'd0, 20'd100}, {20'd0, 20'd0, 20'd0}, 16'd256,
              16'd128, 32'h9ABCDEF0, 1'b1);
    for (int i = 0; i < 1940; i++) begin
      if (i == 900) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_random(i >= 1700);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("sphere_elastic_collision_core_test: PASS");
    end else begin
      $display("sphere_elastic_collision_core_test: FAIL");
    end
    $finish;
  end

endmodule
